// ===== hw/rtl/addressable_led_pulse_encoder_top_defines.svh =====
// Assertion helpers used by the encoder's top-level RTL file.
`ifndef ADDRESSABLE_LED_PULSE_ENCODER_TOP_DEFINES_SVH
`define ADDRESSABLE_LED_PULSE_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ALPE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ALPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/alpe_pkg.sv =====
package alpe_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_HIGH_TIME  = 2'd0;
  localparam logic [1:0] CFG_LOW_TIME   = 2'd1;
  localparam logic [1:0] CFG_RESET_TIME = 2'd2;

  // Reset values of the timing registers.
  localparam logic [15:0] HIGH_TIME_RST  = 16'd65;
  localparam logic [15:0] LOW_TIME_RST   = 16'd15;
  localparam logic [15:0] RESET_TIME_RST = 16'd2400;

  // Bits sent for one pixel.
  localparam logic [4:0] BITS_PER_PIXEL = 5'd24;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_SEND = 3'b010,
    MODE_GAP  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [15:0] high_time;
    logic [15:0] low_time;
    logic [15:0] reset_time;
  } alpe_cfg_t;

  // One tick request: an optional pixel.
  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } alpe_tick_t;

  // One result per tick.
  typedef struct packed {
    logic line_level;
    logic pixel_ready;
    logic busy_res;
    logic underrun;
  } alpe_res_t;

endpackage

// ===== hw/rtl/alpe_cfg.sv =====
module alpe_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output alpe_pkg::alpe_cfg_t cfg
);
  import alpe_pkg::*;

  // Timing registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_time  <= HIGH_TIME_RST;
      cfg.low_time   <= LOW_TIME_RST;
      cfg.reset_time <= RESET_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIGH_TIME:  cfg.high_time  <= cfg_data;
        CFG_LOW_TIME:   cfg.low_time   <= cfg_data;
        CFG_RESET_TIME: cfg.reset_time <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/alpe_core.sv =====
module alpe_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  alpe_pkg::alpe_tick_t tick,
  input  alpe_pkg::alpe_cfg_t  cfg,
  output alpe_pkg::alpe_res_t  res
);
  import alpe_pkg::*;

  // Compare width: holds a duration up to 2^TIMER_WIDTH and any 16-bit register.
  localparam int CW = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;
  localparam logic [CW-1:0] MAX_LEN = {{(CW-1){1'b0}}, 1'b1} << TIMER_WIDTH;

  logic [23:0]            bit_shift, bit_shift_next;
  logic [4:0]             bit_index, bit_index_next;
  logic                   pulse_phase, pulse_phase_next;
  logic [TIMER_WIDTH-1:0] tick_count, tick_count_next;
  mode_t                  mode, mode_next;
  logic                   frame_ending, frame_ending_next;
  logic [24:0]            held_pixel;
  logic                   held_full, held_full_next;

  // State after the pixel intake and a possible start from idle.
  logic                   take;
  logic                   full_a;
  logic [24:0]            pix_a;
  logic                   load_a;
  logic [23:0]            shift_a;
  logic [4:0]             index_a;
  logic                   phase_a;
  logic [TIMER_WIDTH-1:0] count_a;
  mode_t                  mode_a;
  logic                   ending_a;
  logic                   full_b;

  logic [15:0]            len_sel;
  logic [CW-1:0]          len_ext;
  logic [CW-1:0]          lim;
  logic [CW-1:0]          count_inc;
  logic                   done;
  logic [4:0]             index_inc;
  logic                   under;

  // Pixel intake into the holding slot, then start sending if idle.
  always_comb begin
    take     = tick.pixel_valid && !held_full;
    full_a   = held_full || take;
    pix_a    = take ? {tick.last_pixel, tick.red, tick.green, tick.blue} : held_pixel;
    load_a   = (mode != MODE_SEND) && (mode != MODE_GAP) && full_a;
    shift_a  = load_a ? pix_a[23:0] : bit_shift;
    ending_a = load_a ? pix_a[24] : frame_ending;
    full_b   = load_a ? 1'b0 : full_a;
    index_a  = load_a ? 5'd0 : bit_index;
    phase_a  = load_a ? 1'b0 : pulse_phase;
    count_a  = load_a ? '0 : tick_count;
    if (load_a) begin
      mode_a = MODE_SEND;
    end else if ((mode == MODE_SEND) || (mode == MODE_GAP)) begin
      mode_a = mode;
    end else begin
      mode_a = MODE_IDLE;
    end
  end

  // Duration of the current part, with a zero length taken as one tick and
  // a length beyond the timer clamped to its full range.
  always_comb begin
    if (mode_a == MODE_SEND) begin
      len_sel = (shift_a[23] ^ phase_a) ? cfg.high_time : cfg.low_time;
    end else begin
      len_sel = cfg.reset_time;
    end
    len_ext = CW'(len_sel);
    if (len_sel == 16'd0) begin
      lim = CW'(1);
    end else if (len_ext > MAX_LEN) begin
      lim = MAX_LEN;
    end else begin
      lim = len_ext;
    end
    count_inc = CW'(count_a) + CW'(1);
    done      = (count_inc >= lim);
    index_inc = index_a + 5'd1;
  end

  // Timer advance and the bit, pixel and frame boundaries.
  always_comb begin
    bit_shift_next    = shift_a;
    bit_index_next    = index_a;
    pulse_phase_next  = phase_a;
    tick_count_next   = count_inc[TIMER_WIDTH-1:0];
    mode_next         = mode_a;
    frame_ending_next = ending_a;
    held_full_next    = full_b;
    under             = 1'b0;
    unique case (mode_a)
      MODE_SEND: begin
        if (done) begin
          tick_count_next = '0;
          if (!phase_a) begin
            pulse_phase_next = 1'b1;
          end else begin
            pulse_phase_next = 1'b0;
            bit_shift_next   = {shift_a[22:0], 1'b0};
            bit_index_next   = index_inc;
            if (index_inc >= BITS_PER_PIXEL) begin
              priority if (ending_a) begin
                mode_next      = MODE_GAP;
                bit_index_next = 5'd0;
              end else if (full_b) begin
                bit_shift_next    = pix_a[23:0];
                frame_ending_next = pix_a[24];
                held_full_next    = 1'b0;
                bit_index_next    = 5'd0;
              end else begin
                under          = 1'b1;
                mode_next      = MODE_GAP;
                bit_index_next = 5'd0;
              end
            end
          end
        end
      end
      MODE_GAP: begin
        if (done) begin
          tick_count_next   = '0;
          mode_next         = MODE_IDLE;
          frame_ending_next = 1'b0;
        end
      end
      default: begin
        tick_count_next = count_a;
      end
    endcase
  end

  // Result of this tick.
  always_comb begin
    res.line_level  = (mode_a == MODE_SEND) && !phase_a;
    res.pixel_ready = !held_full;
    res.busy_res    = (mode_a == MODE_SEND) || (mode_a == MODE_GAP);
    res.underrun    = under;
  end

  // Encoder state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shift    <= '0;
      bit_index    <= '0;
      pulse_phase  <= 1'b0;
      tick_count   <= '0;
      mode         <= MODE_IDLE;
      frame_ending <= 1'b0;
      held_full    <= 1'b0;
    end else if (step) begin
      bit_shift    <= bit_shift_next;
      bit_index    <= bit_index_next;
      pulse_phase  <= pulse_phase_next;
      tick_count   <= tick_count_next;
      mode         <= mode_next;
      frame_ending <= frame_ending_next;
      held_full    <= held_full_next;
    end
  end

  // The holding slot is written only when it takes a pixel.
  always_ff @(posedge clk) begin
    if (step && take) begin
      held_pixel <= pix_a;
    end
  end

endmodule

// ===== hw/rtl/addressable_led_pulse_encoder_top.sv =====
// Pulse-width encoder for a one-wire chain of addressable RGB LEDs.
// Each request on the input channel (in_valid/in_ready) is one tick of the
// pulse timer; it may offer a pixel (pixel_valid with red, green, blue and
// last_pixel). Every request yields exactly one result on the output channel
// (out_valid/out_ready): the data line level for that tick, pixel_ready
// (the offered pixel was taken), busy_res and a one-tick underrun flag.
// Bits go out MSB first, red then green then blue; after the last pixel the
// line is held low for reset_time ticks.
// The user writes timing registers through cfg_we/cfg_index/cfg_data only while
// the block is idle (the block does not enforce this): 0 high_time, 1 low_time, 2 reset_time.
// A request accepted at a clock edge sits in the input register and is stepped
// through the encoder into the result register once that register is free or
// draining; its result is offered from then on.
// One request is taken every cycle as long as results are drained.
// When the receiver stalls, the result register keeps its result and the
// input register takes at most one more request, so in a steady stream
// in_ready drops in the same cycle as out_ready.
// Reset clears the encoder to idle with an empty pixel slot and loads the
// timing registers with 65, 15 and 2400.
`include "addressable_led_pulse_encoder_top_defines.svh"

module addressable_led_pulse_encoder_top #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pixel_valid,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        last_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        line_level,
  output logic        pixel_ready,
  output logic        busy_res,
  output logic        underrun,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import alpe_pkg::*;

  alpe_cfg_t  cfg;
  alpe_tick_t in_tick;
  alpe_tick_t s_tick;
  logic       s_valid;
  alpe_res_t  core_res;
  alpe_res_t  o_res;
  logic       o_valid;
  logic       advance;

  alpe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held request moves on when the result register is free or draining.
  assign advance  = s_valid && (!o_valid || out_ready);
  assign in_ready = !s_valid || advance;

  assign in_tick = '{pixel_valid: pixel_valid, red: red, green: green, blue: blue,
                     last_pixel: last_pixel};

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_tick <= in_tick;
    end
  end

  alpe_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .tick (s_tick),
    .cfg  (cfg),
    .res  (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (out_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_res <= core_res;
    end
  end

  assign out_valid   = o_valid;
  assign line_level  = o_res.line_level;
  assign pixel_ready = o_res.pixel_ready;
  assign busy_res    = o_res.busy_res;
  assign underrun    = o_res.underrun;

  // The line is only driven high while a frame is being sent.
  `ALPE_ASSERT_IMP(a_line_needs_busy, out_valid && line_level, busy_res, "line high when idle")
  // An underrun ends a pixel with the line low and starts the latch gap.
  `ALPE_ASSERT_IMP(a_underrun_low, out_valid && underrun, busy_res && !line_level, "underrun high")
  // A held request always reaches an empty result register in the next cycle.
  `ALPE_ASSERT_NEXT(a_stage_drains, s_valid && !o_valid, o_valid, "held request not advanced")

endmodule
